FILE: hdl/mfc_pkg.sv
package mfc_pkg;

  localparam int unsigned HeaderBytes = 52;
  localparam int unsigned IdxW        = 6;
  localparam logic [31:0] CrcPoly     = 32'hedb8_8320;
  localparam logic [31:0] CrcOnes     = 32'hffff_ffff;

  // Header layout: first byte index past each field
  localparam logic [IdxW-1:0] EndVersion = 6'd2;
  localparam logic [IdxW-1:0] EndType    = 6'd4;
  localparam logic [IdxW-1:0] EndSource  = 6'd12;
  localparam logic [IdxW-1:0] EndDest    = 6'd20;
  localparam logic [IdxW-1:0] EndTxnHi   = 6'd28;
  localparam logic [IdxW-1:0] EndTxnLo   = 6'd36;
  localparam logic [IdxW-1:0] EndStamp   = 6'd44;
  localparam logic [IdxW-1:0] EndLength  = 6'd48;
  localparam logic [IdxW-1:0] LastHdrIdx = IdxW'(HeaderBytes - 1);

  localparam int unsigned OutDataW = 384;

  typedef enum logic [2:0] {
    StOk       = 3'd0,
    StClosed   = 3'd1,
    StIo       = 3'd2,
    StVersion  = 3'd3,
    StTooLarge = 3'd4,
    StChecksum = 3'd5
  } status_e;

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    status_e     status;
    logic [15:0] message_type;
    logic [63:0] source_id;
    logic [63:0] destination_id;
    logic [63:0] txn_high;
    logic [63:0] txn_low;
    logic [63:0] stamp_ms;
    logic [31:0] body_length;
    logic        last;
  } result_t;

  // Reflected CRC-32, one byte
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (CrcPoly & {32{c[0]}});
    end
    return c;
  endfunction

endpackage

FILE: hdl/mfc_out_fifo.sv
module mfc_out_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_a_i,
  input  mfc_pkg::result_t word_a_i,
  input  logic             push_b_i,
  input  mfc_pkg::result_t word_b_i,
  input  logic             pop_i,
  output mfc_pkg::result_t head_o,
  output logic             valid_o,
  output logic             room_o
);
  import mfc_pkg::*;

  localparam int unsigned Depth = 3;

  result_t     entry_q [Depth];
  logic [1:0]  wr_ptr_q, wr_ptr_d;
  logic [1:0]  rd_ptr_q, rd_ptr_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [1:0]  wr_next;

  function automatic logic [1:0] inc_ptr(input logic [1:0] p);
    return (p == 2'(Depth - 1)) ? 2'd0 : p + 2'd1;
  endfunction

  assign wr_next = inc_ptr(wr_ptr_q);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_a_i && push_b_i) begin
      wr_ptr_d = inc_ptr(wr_next);
    end else if (push_a_i) begin
      wr_ptr_d = wr_next;
    end
    if (pop_i) begin
      rd_ptr_d = inc_ptr(rd_ptr_q);
    end
    cnt_d = cnt_q + {1'b0, push_a_i} + {1'b0, push_a_i & push_b_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_a_i) begin
      entry_q[wr_ptr_q] <= word_a_i;
    end
    if (push_a_i && push_b_i) begin
      entry_q[wr_next] <= word_b_i;
    end
  end

  assign head_o  = entry_q[rd_ptr_q];
  assign valid_o = (cnt_q != 2'd0);
  // Two free slots needed: one input word may give two results
  assign room_o  = (cnt_q <= 2'd1);

endmodule

FILE: hdl/message_frame_checker.sv
// Framed message receiver. Each input word is one received byte (tdata[7:0]) or,
// with tuser high, a peer-closed marker. A 52-byte big-endian header (version, type,
// source, destination, 128-bit transaction id, timestamp, payload length, checksum)
// is collected and checked against expected_version (register 0) and payload_limit
// (register 1). A reflected CRC-32 runs over the header, checksum bytes counted as
// zero, then over the payload. Payload bytes leave as words with tuser low; each
// message ends with one word with tuser high carrying the status and the header
// fields, if complete. After any status word the block looks for a fresh header.
// tlast marks the final word caused by one input word. Throughput is one input word
// per clock while the output queue has room: a header byte takes one CRC step and
// one field shift, a payload byte one CRC step, before the queue. The last payload
// byte produces two output words, so with a sink taking one word per clock the input
// stalls after it; the three-entry output queue accepts input only with two free.
module message_frame_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // [7:0] rx_byte
  input  logic                          s_axis_tuser,  // [0] peer_closed
  // output stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [7:0] payload_byte, [10:8] status, [26:11] message_type, [90:27] source_id,
  // [154:91] destination_id, [218:155] txn_high, [282:219] txn_low,
  // [346:283] stamp_ms, [378:347] body_length, [383:379] zero
  output logic [mfc_pkg::OutDataW-1:0]  m_axis_tdata,
  output logic                          m_axis_tuser,  // [0] result_kind
  output logic                          m_axis_tlast,  // last_of_run
  // configuration writes
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic                          cfg_index_i,
  input  logic [31:0]                   cfg_data_i
);
  import mfc_pkg::*;

  typedef enum logic {
    PhHeader,
    PhPayload
  } phase_e;

  localparam logic CfgVersion = 1'b0;
  localparam logic CfgLimit   = 1'b1;

  // configuration
  logic [15:0] exp_version_q;
  logic [31:0] limit_q;

  // control
  phase_e          phase_q, phase_d;
  logic [IdxW-1:0] hdr_idx_q, hdr_idx_d;
  logic [31:0]     left_q, left_d;
  logic [31:0]     crc_q, crc_d;

  // header capture
  logic [15:0] version_q, version_d;
  logic [15:0] type_q, type_d;
  logic [63:0] source_q, source_d;
  logic [63:0] dest_q, dest_d;
  logic [63:0] txn_hi_q, txn_hi_d;
  logic [63:0] txn_lo_q, txn_lo_d;
  logic [63:0] stamp_q, stamp_d;
  logic [31:0] length_q, length_d;
  logic [31:0] crc_seen_q, crc_seen_d;

  logic        accept;
  logic [7:0]  rx_byte;
  logic        closed;
  logic [7:0]  crc_feed;
  logic [31:0] crc_step;
  logic        crc_match;
  logic        push_a, push_b;
  result_t     word_a, word_b, head;
  logic        pop;

  assign rx_byte = s_axis_tdata;
  assign closed  = s_axis_tuser;
  assign accept  = s_axis_tvalid && s_axis_tready;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_version_q <= 16'd1;
      limit_q       <= 32'd65536;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgVersion: exp_version_q <= cfg_data_i[15:0];
        CfgLimit:   limit_q       <= cfg_data_i;
        default:    ;
      endcase
    end
  end

  // Build a status word from the (possibly just completed) header
  function automatic result_t final_word(input status_e st, input logic with_hdr,
                                         input logic [15:0] typ, input logic [63:0] src,
                                         input logic [63:0] dst, input logic [63:0] th,
                                         input logic [63:0] tl, input logic [63:0] stp,
                                         input logic [31:0] len);
    result_t w;
    w              = '0;
    w.kind         = 1'b1;
    w.status       = st;
    w.last         = 1'b1;
    if (with_hdr) begin
      w.message_type   = typ;
      w.source_id      = src;
      w.destination_id = dst;
      w.txn_high       = th;
      w.txn_low        = tl;
      w.stamp_ms       = stp;
      w.body_length    = len;
    end
    return w;
  endfunction

  // One CRC step per accepted byte; checksum bytes of the header count as zero
  assign crc_feed = (phase_q == PhHeader && hdr_idx_q >= EndLength) ? 8'd0 : rx_byte;
  assign crc_step = crc_byte(crc_q, crc_feed);

  // On the last header byte the checksum field is still taking its final byte
  assign crc_match = ((crc_step ^ CrcOnes) ==
                      ((phase_q == PhPayload) ? crc_seen_q : {crc_seen_q[23:0], rx_byte}));

  always_comb begin
    phase_d    = phase_q;
    hdr_idx_d  = hdr_idx_q;
    left_d     = left_q;
    crc_d      = crc_q;
    version_d  = version_q;
    type_d     = type_q;
    source_d   = source_q;
    dest_d     = dest_q;
    txn_hi_d   = txn_hi_q;
    txn_lo_d   = txn_lo_q;
    stamp_d    = stamp_q;
    length_d   = length_q;
    crc_seen_d = crc_seen_q;
    push_a     = 1'b0;
    push_b     = 1'b0;
    word_a     = '0;
    word_b     = '0;

    if (accept) begin
      if (phase_q == PhPayload) begin
        if (closed) begin
          push_a = 1'b1;
          word_a = final_word(StClosed, 1'b1, type_q, source_q, dest_q, txn_hi_q,
                              txn_lo_q, stamp_q, length_q);
        end else begin
          crc_d               = crc_step;
          left_d              = left_q - 32'd1;
          push_a              = 1'b1;
          word_a.payload_byte = rx_byte;
          word_a.last         = (left_q != 32'd1);
          if (left_q == 32'd1) begin
            // last payload byte: byte word, then status word
            push_b = 1'b1;
            word_b = final_word(crc_match ? StOk : StChecksum, 1'b1, type_q, source_q,
                                dest_q, txn_hi_q, txn_lo_q, stamp_q, length_q);
          end
        end
      end else begin
        if (closed) begin
          push_a = 1'b1;
          word_a = final_word((hdr_idx_q == '0) ? StClosed : StIo, 1'b0, '0, '0, '0,
                              '0, '0, '0, '0);
        end else begin
          // shift the byte into the field it belongs to
          if (hdr_idx_q < EndVersion)     version_d  = {version_q[7:0], rx_byte};
          else if (hdr_idx_q < EndType)   type_d     = {type_q[7:0], rx_byte};
          else if (hdr_idx_q < EndSource) source_d   = {source_q[55:0], rx_byte};
          else if (hdr_idx_q < EndDest)   dest_d     = {dest_q[55:0], rx_byte};
          else if (hdr_idx_q < EndTxnHi)  txn_hi_d   = {txn_hi_q[55:0], rx_byte};
          else if (hdr_idx_q < EndTxnLo)  txn_lo_d   = {txn_lo_q[55:0], rx_byte};
          else if (hdr_idx_q < EndStamp)  stamp_d    = {stamp_q[55:0], rx_byte};
          else if (hdr_idx_q < EndLength) length_d   = {length_q[23:0], rx_byte};
          else                            crc_seen_d = {crc_seen_q[23:0], rx_byte};
          crc_d     = crc_step;
          hdr_idx_d = hdr_idx_q + IdxW'(1);
          if (hdr_idx_q == LastHdrIdx) begin
            hdr_idx_d = '0;
            if (version_d != exp_version_q) begin
              push_a = 1'b1;
              word_a = final_word(StVersion, 1'b1, type_d, source_d, dest_d, txn_hi_d,
                                  txn_lo_d, stamp_d, length_d);
            end else if (length_d > limit_q) begin
              push_a = 1'b1;
              word_a = final_word(StTooLarge, 1'b1, type_d, source_d, dest_d, txn_hi_d,
                                  txn_lo_d, stamp_d, length_d);
            end else if (length_d == 32'd0) begin
              push_a = 1'b1;
              word_a = final_word(crc_match ? StOk : StChecksum, 1'b1, type_d,
                                  source_d, dest_d, txn_hi_d, txn_lo_d, stamp_d,
                                  length_d);
            end else begin
              phase_d = PhPayload;
              left_d  = length_d;
            end
          end
        end
      end

      // any status word sends the block back to header hunting
      if ((push_a && word_a.kind) || push_b) begin
        phase_d   = PhHeader;
        hdr_idx_d = '0;
        left_d    = '0;
        crc_d     = CrcOnes;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhHeader;
      hdr_idx_q  <= '0;
      left_q     <= '0;
      crc_q      <= CrcOnes;
      version_q  <= '0;
      type_q     <= '0;
      source_q   <= '0;
      dest_q     <= '0;
      txn_hi_q   <= '0;
      txn_lo_q   <= '0;
      stamp_q    <= '0;
      length_q   <= '0;
      crc_seen_q <= '0;
    end else begin
      phase_q    <= phase_d;
      hdr_idx_q  <= hdr_idx_d;
      left_q     <= left_d;
      crc_q      <= crc_d;
      version_q  <= version_d;
      type_q     <= type_d;
      source_q   <= source_d;
      dest_q     <= dest_d;
      txn_hi_q   <= txn_hi_d;
      txn_lo_q   <= txn_lo_d;
      stamp_q    <= stamp_d;
      length_q   <= length_d;
      crc_seen_q <= crc_seen_d;
    end
  end

  // Result queue decouples the sink from the byte path
  assign pop = m_axis_tvalid && m_axis_tready;

  mfc_out_fifo u_out_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_a_i (push_a),
    .word_a_i (word_a),
    .push_b_i (push_b),
    .word_b_i (word_b),
    .pop_i    (pop),
    .head_o   (head),
    .valid_o  (m_axis_tvalid),
    .room_o   (s_axis_tready)
  );

  assign m_axis_tuser = head.kind;
  assign m_axis_tlast = head.last;
  assign m_axis_tdata = {5'd0, head.body_length, head.stamp_ms, head.txn_low,
                         head.txn_high, head.destination_id, head.source_id,
                         head.message_type, head.status, head.payload_byte};

endmodule
